// File: rtl/gfpc_pkg.sv
// gfpc_pkg: shared types, constants and scale tables for the gauge frame converter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gfpc_pkg;

    localparam int IN_W     = 40;
    localparam int OUT_W    = 128;
    localparam int USER_W   = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;
    localparam int DIV_W    = 105;
    localparam int DVS_W    = 56;
    localparam int CNT_W    = 7;
    localparam int TORR_DIGITS = 5;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] TORR_LAST = CNT_W'(TORR_DIGITS - 1);
    localparam logic [63:0]      MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    // torr = floor((50 * |pa| + 3333) / 6666), same as rounding |pa| * 100 / 13332
    localparam logic [5:0]       TORR_SCALE = 6'd50;
    localparam logic [11:0]      TORR_BIAS  = 12'd3333;
    localparam logic [12:0]      TORR_DIV   = 13'd6666;
    // ceil(2^42 / 6666), exact quotient for any 29-bit digit step
    localparam logic [29:0]      TORR_RECIP = 30'd659772954;

    localparam logic [7:0] PAGE_SCALE_A = 8'd2;
    localparam logic [7:0] PAGE_SCALE_B = 8'd3;
    localparam logic [7:0] PAGE_DIVISOR = 8'd4;

    localparam logic [1:0] UNIT_HPA  = 2'd0;
    localparam logic [1:0] UNIT_MMHG = 2'd1;
    localparam logic [1:0] UNIT_PA   = 2'd2;
    localparam logic [1:0] UNIT_NONE = 2'd3;

    localparam logic [2:0] MANT_UNSET = 3'd7;
    localparam logic [3:0] EXP_UNSET  = 4'd15;
    localparam logic [2:0] CODE_UNSET = 3'd0;
    localparam logic [2:0] NUM_MBAR   = 3'd1;
    localparam logic [2:0] NUM_TORR   = 3'd2;
    localparam logic [2:0] NUM_PA     = 3'd3;
    localparam logic [2:0] NUM_WIDE   = 3'd4;
    localparam logic [2:0] DIV_24000  = 3'd1;
    localparam logic [2:0] DIV_32000  = 3'd2;
    localparam logic [2:0] DIV_26400  = 3'd3;
    localparam logic [2:0] DIV_32767  = 3'd4;

    // one classified frame as it travels from front to back
    typedef struct packed {
        logic [1:0]  unit;
        logic        valid;
        logic        neg;
        logic [15:0] mag;
        logic [2:0]  mant;
        logic [3:0]  expo;
        logic [2:0]  num;
        logic [2:0]  dvs;
    } cmd_t;

    function automatic logic [13:0] a_num(input logic [2:0] c);
        case (c)
            NUM_TORR: a_num = 14'd1;
            NUM_MBAR,
            NUM_PA,
            NUM_WIDE: a_num = 14'd13332;
            default:  a_num = 14'd1;
        endcase
    endfunction

    function automatic logic [13:0] a_den(input logic [2:0] c);
        case (c)
            NUM_MBAR: a_den = 14'd10000;
            NUM_PA:   a_den = 14'd100;
            default:  a_den = 14'd1;
        endcase
    endfunction

    function automatic logic [13:0] unit_num(input logic [1:0] u);
        case (u)
            UNIT_HPA:  unit_num = 14'd10000;
            UNIT_MMHG: unit_num = 14'd13332;
            default:   unit_num = 14'd1;
        endcase
    endfunction

    function automatic logic [13:0] unit_den(input logic [1:0] u);
        case (u)
            UNIT_HPA:  unit_den = 14'd13332;
            UNIT_MMHG: unit_den = 14'd100;
            default:   unit_den = 14'd1;
        endcase
    endfunction

    function automatic logic [5:0] mant_tenths(input logic [2:0] c);
        case (c)
            3'd0:    mant_tenths = 6'd10;
            3'd1:    mant_tenths = 6'd11;
            3'd2:    mant_tenths = 6'd20;
            3'd3:    mant_tenths = 6'd25;
            3'd4:    mant_tenths = 6'd50;
            default: mant_tenths = 6'd0;
        endcase
    endfunction

    function automatic logic [23:0] pow10(input logic [3:0] c);
        case (c)
            4'd0:    pow10 = 24'd1;
            4'd1:    pow10 = 24'd10;
            4'd2:    pow10 = 24'd100;
            4'd3:    pow10 = 24'd1000;
            4'd4:    pow10 = 24'd10000;
            4'd5:    pow10 = 24'd100000;
            4'd6:    pow10 = 24'd1000000;
            4'd7:    pow10 = 24'd10000000;
            default: pow10 = 24'd0;
        endcase
    endfunction

    function automatic logic [14:0] b_val(input logic [2:0] c);
        case (c)
            DIV_24000: b_val = 15'd24000;
            DIV_32000: b_val = 15'd32000;
            DIV_26400: b_val = 15'd26400;
            DIV_32767: b_val = 15'd32767;
            default:   b_val = 15'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/gfpc_front.sv
// gfpc_front: accepts frames, keeps the scale codes and classifies each frame
// depends on gfpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gfpc_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [gfpc_pkg::IN_W-1:0] s_axis_tdata,
    input  wire logic                      q_full,
    output logic                           q_push,
    output gfpc_pkg::cmd_t                 q_cmd
);

    logic [2:0] mant_reg, mant_next;
    logic [3:0] exp_reg, exp_next;
    logic [2:0] num_reg, num_next;
    logic [2:0] dvs_reg, dvs_next;

    logic [7:0]  page;
    logic [7:0]  status;
    logic [7:0]  type_b;
    logic [15:0] raw;
    logic [1:0]  unit;
    logic [3:0]  mnib;
    logic [3:0]  enib;

    assign page   = s_axis_tdata[7:0];
    assign status = s_axis_tdata[15:8];
    assign type_b = s_axis_tdata[23:16];
    assign raw    = s_axis_tdata[39:24];
    assign unit   = status[5:4];
    assign mnib   = type_b[7:4];
    assign enib   = type_b[3:0];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        mant_next = mant_reg;
        exp_next  = exp_reg;
        num_next  = num_reg;
        dvs_next  = dvs_reg;
        if (page == gfpc_pkg::PAGE_SCALE_A || page == gfpc_pkg::PAGE_SCALE_B)
        begin
            if (enib <= 4'd7)
                exp_next = enib;
            if (mnib <= 4'd4)
                mant_next = mnib[2:0];
            if (mnib != 4'd1)
            begin
                case (unit)
                    gfpc_pkg::UNIT_HPA:
                    begin
                        num_next = gfpc_pkg::NUM_MBAR;
                        dvs_next = gfpc_pkg::DIV_24000;
                    end
                    gfpc_pkg::UNIT_MMHG:
                    begin
                        num_next = gfpc_pkg::NUM_TORR;
                        dvs_next = gfpc_pkg::DIV_32000;
                    end
                    gfpc_pkg::UNIT_PA:
                    begin
                        num_next = gfpc_pkg::NUM_PA;
                        dvs_next = gfpc_pkg::DIV_24000;
                    end
                    default:
                    begin
                        num_next = num_reg;
                        dvs_next = dvs_reg;
                    end
                endcase
            end
            else if (unit == gfpc_pkg::UNIT_HPA)
            begin
                num_next = gfpc_pkg::NUM_WIDE;
                dvs_next = gfpc_pkg::DIV_26400;
            end
        end
        else if (page == gfpc_pkg::PAGE_DIVISOR)
        begin
            dvs_next = gfpc_pkg::DIV_32767;
        end
    end

    always_comb
    begin
        q_cmd.unit  = unit;
        q_cmd.valid = mant_next <= 3'd4 && exp_next <= 4'd7 &&
                      num_next != gfpc_pkg::CODE_UNSET && num_next <= 3'd4 &&
                      dvs_next != gfpc_pkg::CODE_UNSET && dvs_next <= 3'd4;
        q_cmd.neg   = raw[15];
        q_cmd.mag   = raw[15] ? 16'(~raw + 16'd1) : raw;
        q_cmd.mant  = mant_next;
        q_cmd.expo  = exp_next;
        q_cmd.num   = num_next;
        q_cmd.dvs   = dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mant_reg <= gfpc_pkg::MANT_UNSET;
            exp_reg  <= gfpc_pkg::EXP_UNSET;
            num_reg  <= gfpc_pkg::CODE_UNSET;
            dvs_reg  <= gfpc_pkg::CODE_UNSET;
        end
        else if (q_push)
        begin
            mant_reg <= mant_next;
            exp_reg  <= exp_next;
            num_reg  <= num_next;
            dvs_reg  <= dvs_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gfpc_queue.sv
// gfpc_queue: short command queue between front and back
// depends on gfpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gfpc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gfpc_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output gfpc_pkg::cmd_t      head
);

    gfpc_pkg::cmd_t mem_reg [gfpc_pkg::QDEPTH];
    logic [gfpc_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [gfpc_pkg::QCNT_W-1:0] cnt_reg;

    assign full      = cnt_reg == gfpc_pkg::QCNT_W'(gfpc_pkg::QDEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gfpc_back.sv
// gfpc_back: scale multiplies, serial rounding divider, torr reciprocal divider, output register
// depends on gfpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gfpc_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_not_empty,
    input  wire gfpc_pkg::cmd_t               q_head,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [gfpc_pkg::OUT_W-1:0]        m_axis_tdata,
    output logic [gfpc_pkg::USER_W-1:0]       m_axis_tuser
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M1   = 4'd1;
    localparam logic [3:0] ST_M2   = 4'd2;
    localparam logic [3:0] ST_M3   = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_PRND = 4'd5;
    localparam logic [3:0] ST_TSET = 4'd6;
    localparam logic [3:0] ST_TMUL = 4'd7;
    localparam logic [3:0] ST_TRND = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;
    localparam logic [3:0] ST_TSUB = 4'd10;

    localparam int DW = gfpc_pkg::DIV_W;
    localparam int VW = gfpc_pkg::DVS_W;

    logic [3:0]          state_reg;
    gfpc_pkg::cmd_t      cmd_reg;
    logic [27:0]         n1_reg, d1_reg;
    logic [28:0]         m_reg, db_reg;
    logic [56:0]         n_reg;
    logic [VW-1:0]       dvs_reg;
    logic [DW-1:0]       num_reg;
    logic [VW-1:0]       rem_reg;
    logic [63:0]         quo_reg;
    logic                ovf_reg;
    logic [gfpc_pkg::CNT_W-1:0] cnt_reg;
    logic [63:0]         pa_reg, torr_reg, last_pa_reg;
    logic [79:0]         tx_reg;
    logic [12:0]         tr_reg;
    logic [15:0]         tqd_reg;

    logic                out_valid_reg;
    logic [63:0]         out_pa_reg, out_torr_reg;
    logic [1:0]          out_unit_reg;
    logic                out_ok_reg;

    // one restoring division step
    logic [VW:0]   rs;
    logic          ge;
    logic [VW-1:0] rem_next;
    // final rounding of the quotient
    logic          half;
    logic [64:0]   qr;
    logic [63:0]   mag_rnd;
    logic [63:0]   pa_abs;
    logic          out_load;
    // one 16-bit digit of the torr division
    logic [28:0]   tstep;
    logic [57:0]   tprod;

    assign rs       = {rem_reg, num_reg[DW-1]};
    assign ge       = rs >= {1'b0, dvs_reg};
    assign rem_next = ge ? VW'(rs - {1'b0, dvs_reg}) : rs[VW-1:0];
    assign half     = {rem_reg, 1'b0} >= {1'b0, dvs_reg};
    assign qr       = {1'b0, quo_reg} + 65'(half);
    assign mag_rnd  = (ovf_reg || qr[64] || qr[63]) ? gfpc_pkg::MAG_MAX : qr[63:0];
    assign pa_abs   = pa_reg[63] ? 64'(~pa_reg + 64'd1) : pa_reg;
    assign tstep    = {tr_reg, tx_reg[79:64]};
    assign tprod    = 58'(tstep) * 58'(gfpc_pkg::TORR_RECIP);

    assign q_pop    = state_reg == ST_IDLE && q_not_empty;
    assign out_load = state_reg == ST_OUT && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_torr_reg, out_pa_reg};
    assign m_axis_tuser  = {out_ok_reg, out_unit_reg};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg  <= q_head;
                pa_reg   <= (q_head.valid && q_head.unit == gfpc_pkg::UNIT_NONE) ?
                            last_pa_reg : '0;
                torr_reg <= '0;
            end
            ST_M1:
            begin
                n1_reg <= 28'(gfpc_pkg::a_num(cmd_reg.num)) * 28'(gfpc_pkg::unit_num(cmd_reg.unit));
                d1_reg <= 28'(gfpc_pkg::a_den(cmd_reg.num)) * 28'(gfpc_pkg::unit_den(cmd_reg.unit));
                m_reg  <= 29'(gfpc_pkg::mant_tenths(cmd_reg.mant)) *
                          29'(gfpc_pkg::pow10(cmd_reg.expo));
                db_reg <= 29'(gfpc_pkg::b_val(cmd_reg.dvs)) * 29'd10000;
            end
            ST_M2:
            begin
                n_reg   <= 57'(n1_reg) * 57'(m_reg);
                dvs_reg <= VW'(d1_reg) * VW'(db_reg);
            end
            ST_M3:
            begin
                num_reg <= {73'(n_reg) * 73'(cmd_reg.mag), 32'd0};
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= num_reg << 1;
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[62:0], ge};
                ovf_reg <= ovf_reg | quo_reg[63];
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_PRND:
            begin
                pa_reg <= cmd_reg.neg ? 64'(~mag_rnd + 64'd1) : mag_rnd;
            end
            ST_TSET:
            begin
                tx_reg  <= 80'(69'(pa_abs) * 69'(gfpc_pkg::TORR_SCALE) +
                               69'(gfpc_pkg::TORR_BIAS));
                tr_reg  <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_TMUL:
            begin
                tqd_reg <= tprod[57:42];
            end
            ST_TSUB:
            begin
                tr_reg  <= 13'(tstep - 29'(tqd_reg) * 29'(gfpc_pkg::TORR_DIV));
                tx_reg  <= tx_reg << 16;
                quo_reg <= {quo_reg[47:0], tqd_reg};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_TRND:
            begin
                torr_reg <= pa_reg[63] ? 64'(~quo_reg + 64'd1) : quo_reg;
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
        if (out_load)
        begin
            out_pa_reg   <= pa_reg;
            out_torr_reg <= torr_reg;
            out_unit_reg <= cmd_reg.unit;
            out_ok_reg   <= cmd_reg.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_pa_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        if (!q_head.valid)
                            state_reg <= ST_OUT;
                        else if (q_head.unit == gfpc_pkg::UNIT_NONE)
                            state_reg <= ST_TSET;
                        else
                            state_reg <= ST_M1;
                    end
                end
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_M3;
                ST_M3:   state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (cnt_reg == gfpc_pkg::DIV_LAST)
                        state_reg <= ST_PRND;
                end
                ST_PRND:
                begin
                    last_pa_reg <= cmd_reg.neg ? 64'(~mag_rnd + 64'd1) : mag_rnd;
                    state_reg   <= ST_TSET;
                end
                ST_TSET: state_reg <= ST_TMUL;
                ST_TMUL: state_reg <= ST_TSUB;
                ST_TSUB:
                begin
                    if (cnt_reg == gfpc_pkg::TORR_LAST)
                        state_reg <= ST_TRND;
                    else
                        state_reg <= ST_TMUL;
                end
                ST_TRND: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // remainder stays below the divisor through every step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

    // step counter never runs past the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> cnt_reg <= gfpc_pkg::DIV_LAST)
        else $error("divider step counter overrun");

    // torr digit remainder stays below the constant divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TMUL || state_reg == ST_TSUB) |-> tr_reg < gfpc_pkg::TORR_DIV)
        else $error("torr digit remainder not below divisor");

    // a result without valid scale carries zero pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_pa_reg == '0 && out_torr_reg == '0))
        else $error("unscaled result with nonzero pressure");

    // a negative torr result always comes with a negative pascal result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_torr_reg[63]) |-> out_pa_reg[63])
        else $error("torr sign differs from pascal sign");

endmodule

`default_nettype wire

// File: rtl/gauge_frame_pressure_convert.sv
// gauge_frame_pressure_convert: top level, front classifier, queue and back converter
// depends on gfpc_pkg, gfpc_front, gfpc_queue, gfpc_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one decoded gauge frame per transfer and returns one pressure result per frame,
// in order. Frames are accepted into a two-entry queue as long as it has room, so the
// input side keeps flowing while a result waits at the output register. The back end
// handles one frame at a time and sets the rate: a frame with valid scale runs a
// 105-step bit-serial division for pascal, then the torr conversion as five 16-bit
// reciprocal-multiply digits; a frame on unit "none" with valid scale runs only the
// torr conversion; a frame while any scale code is unset goes straight to the output
// register. Each result may further wait for m_axis_tready. Scale codes are updated
// as frames enter, so results follow the frame order exactly.
module gauge_frame_pressure_convert (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // page_number[7:0], status_byte[15:8], type_byte[23:16], raw_reading[39:24]
    input  wire logic [gfpc_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // pressure_pascal[63:0], pressure_torr_out[127:64]
    output logic [gfpc_pkg::OUT_W-1:0]         m_axis_tdata,
    // unit_code[1:0], scale_valid[2]
    output logic [gfpc_pkg::USER_W-1:0]        m_axis_tuser
);

    gfpc_pkg::cmd_t push_cmd;
    gfpc_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;

    gfpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (full),
        .q_push        (push),
        .q_cmd         (push_cmd)
    );

    gfpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    gfpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (not_empty),
        .q_head        (head),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: tb/sv/gfpc_checker.sv
// gfpc_checker: watches both streams of the gauge frame converter, predicts each result
// and compares it field by field; depends on gfpc_pkg
`timescale 1ns / 1ps

module gfpc_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [gfpc_pkg::IN_W-1:0] s_axis_tdata,
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [gfpc_pkg::OUT_W-1:0] m_axis_tdata,
    input  wire logic [gfpc_pkg::USER_W-1:0] m_axis_tuser,
    output int                             fail_count,
    output int                             pending
);

    typedef struct {
        logic [63:0] pa;
        logic [63:0] torr;
        logic [1:0]  unit;
        logic        valid;
    } pressure_t;

    pressure_t   expected_q[$];
    logic [2:0]  mant_st;
    logic [3:0]  exp_st;
    logic [2:0]  num_st;
    logic [2:0]  dvs_st;
    logic [63:0] last_pa;

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // rounded n / d, halves away from zero, saturated
    function automatic logic [63:0] round_div(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = n / d;
        r = n % d;
        if (r >= d - r)
            q = q + 128'd1;
        if (q > {64'd0, gfpc_pkg::MAG_MAX})
            return gfpc_pkg::MAG_MAX;
        return q[63:0];
    endfunction

    function automatic logic [63:0] torr_of(input logic [63:0] pa);
        logic [63:0] mag;
        logic [63:0] q;
        mag = pa[63] ? -pa : pa;
        q = round_div({64'd0, mag} * 128'd100, 128'd13332);
        return pa[63] ? -q : q;
    endfunction

    function automatic logic [127:0] tenths(input logic [2:0] c);
        case (c)
            3'd0:    return 128'd10;
            3'd1:    return 128'd11;
            3'd2:    return 128'd20;
            3'd3:    return 128'd25;
            default: return 128'd50;
        endcase
    endfunction

    task automatic predict_frame(input logic [gfpc_pkg::IN_W-1:0] d);
        logic [7:0]   page;
        logic [1:0]   unit;
        logic [3:0]   mnib;
        logic [3:0]   enib;
        logic [15:0]  raw;
        logic [15:0]  mag;
        logic [127:0] n;
        logic [127:0] den;
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] bv;
        logic [127:0] un;
        logic [127:0] ud;
        logic [63:0]  q;
        pressure_t    e;
        page = d[7:0];
        unit = d[13:12];
        enib = d[19:16];
        mnib = d[23:20];
        raw  = d[39:24];
        if (page == gfpc_pkg::PAGE_SCALE_A || page == gfpc_pkg::PAGE_SCALE_B)
        begin
            if (enib <= 4'd7)
                exp_st = enib;
            if (mnib <= 4'd4)
                mant_st = mnib[2:0];
            if (mnib != 4'd1)
            begin
                if (unit == gfpc_pkg::UNIT_HPA)
                begin
                    num_st = gfpc_pkg::NUM_MBAR;
                    dvs_st = gfpc_pkg::DIV_24000;
                end
                else if (unit == gfpc_pkg::UNIT_MMHG)
                begin
                    num_st = gfpc_pkg::NUM_TORR;
                    dvs_st = gfpc_pkg::DIV_32000;
                end
                else if (unit == gfpc_pkg::UNIT_PA)
                begin
                    num_st = gfpc_pkg::NUM_PA;
                    dvs_st = gfpc_pkg::DIV_24000;
                end
            end
            else if (unit == gfpc_pkg::UNIT_HPA)
            begin
                num_st = gfpc_pkg::NUM_WIDE;
                dvs_st = gfpc_pkg::DIV_26400;
            end
        end
        else if (page == gfpc_pkg::PAGE_DIVISOR)
        begin
            dvs_st = gfpc_pkg::DIV_32767;
        end
        e.unit = unit;
        e.valid = mant_st <= 3'd4 && exp_st <= 4'd7 &&
                  num_st != gfpc_pkg::CODE_UNSET && num_st <= 3'd4 &&
                  dvs_st != gfpc_pkg::CODE_UNSET && dvs_st <= 3'd4;
        e.pa = 64'd0;
        e.torr = 64'd0;
        if (e.valid)
        begin
            if (unit == gfpc_pkg::UNIT_NONE)
            begin
                e.pa = last_pa;
            end
            else
            begin
                an = (num_st == gfpc_pkg::NUM_TORR) ? 128'd1 : 128'd13332;
                ad = (num_st == gfpc_pkg::NUM_MBAR) ? 128'd10000 :
                     (num_st == gfpc_pkg::NUM_PA) ? 128'd100 : 128'd1;
                case (dvs_st)
                    gfpc_pkg::DIV_24000: bv = 128'd24000;
                    gfpc_pkg::DIV_32000: bv = 128'd32000;
                    gfpc_pkg::DIV_26400: bv = 128'd26400;
                    default:             bv = 128'd32767;
                endcase
                un = (unit == gfpc_pkg::UNIT_HPA) ? 128'd10000 :
                     (unit == gfpc_pkg::UNIT_MMHG) ? 128'd13332 : 128'd1;
                ud = (unit == gfpc_pkg::UNIT_HPA) ? 128'd13332 :
                     (unit == gfpc_pkg::UNIT_MMHG) ? 128'd100 : 128'd1;
                mag = raw[15] ? -raw : raw;
                n = an * tenths(mant_st) * (128'd10 ** exp_st) * un;
                den = ad * bv * 128'd10000 * ud;
                q = round_div((n * {112'd0, mag}) << 32, den);
                e.pa = raw[15] ? -q : q;
                last_pa = e.pa;
            end
            e.torr = torr_of(e.pa);
        end
        expected_q.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pressure_t e;
        if (!rst_n)
        begin
            mant_st = gfpc_pkg::MANT_UNSET;
            exp_st  = gfpc_pkg::EXP_UNSET;
            num_st  = gfpc_pkg::CODE_UNSET;
            dvs_st  = gfpc_pkg::CODE_UNSET;
            last_pa = 64'd0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_frame(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report("unexpected result", m_axis_tdata[63:0], 64'd0);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (m_axis_tdata[63:0] !== e.pa)
                        report("pascal", m_axis_tdata[63:0], e.pa);
                    if (m_axis_tdata[127:64] !== e.torr)
                        report("torr", m_axis_tdata[127:64], e.torr);
                    if (m_axis_tuser[1:0] !== e.unit)
                        report("unit", 64'(m_axis_tuser[1:0]), 64'(e.unit));
                    if (m_axis_tuser[2] !== e.valid)
                        report("valid", 64'(m_axis_tuser[2]), 64'(e.valid));
                end
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// testbench: drives gauge frames into gauge_frame_pressure_convert with random gaps
// and stalls; depends on gfpc_pkg and gfpc_checker for prediction and comparison
`timescale 1ns / 1ps

module testbench;

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [gfpc_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [gfpc_pkg::OUT_W-1:0] m_axis_tdata;
    logic [gfpc_pkg::USER_W-1:0] m_axis_tuser;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit stim_done = 0;

    localparam int CYCLE_LIMIT = 10000000;

    always #6 clk = ~clk;

    gauge_frame_pressure_convert u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    gfpc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // one frame transfer, then a random gap with valid low
    task automatic send_frame(input logic [7:0] page, input logic [7:0] status,
                              input logic [7:0] typ, input logic [15:0] raw);
        int g;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {raw, typ, status, page};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rnd_status(input logic [1:0] u);
        logic [7:0] s;
        s = 8'($urandom);
        s[5:4] = u;
        return s;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        int g;
        forever
        begin
            @(posedge clk);
            g = gap_len();
            if (!stim_done && g > 8 && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 0;
                repeat (g) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        int i;
        int k;
        logic [7:0] page;
        logic [7:0] typ;
        logic [1:0] u;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: unset factors first, then every unit, mantissa, number and divisor code, extremes of reading
        send_frame(8'd0, 8'h00, 8'h00, 16'h7FFF);
        send_frame(8'd4, 8'hFF, 8'hFF, 16'h8000);
        send_frame(8'd2, 8'h00, 8'hF8, 16'h1234);
        send_frame(8'd2, 8'h00, 8'h07, 16'h7FFF);
        send_frame(8'd0, 8'h00, 8'h00, 16'h8000);
        send_frame(8'd0, 8'h30, 8'h00, 16'h0001);
        send_frame(8'd3, 8'h10, 8'h40, 16'h7FFF);
        send_frame(8'd0, 8'h10, 8'h00, 16'hFFFF);
        send_frame(8'd3, 8'h20, 8'h27, 16'h8000);
        send_frame(8'd4, 8'h20, 8'h00, 16'h7FFF);
        send_frame(8'd2, 8'h00, 8'h17, 16'h8001);
        send_frame(8'd2, 8'h10, 8'h10, 16'h0000);
        send_frame(8'd2, 8'h30, 8'h33, 16'h4000);
        send_frame(8'd1, 8'h30, 8'hFF, 16'h0000);
        send_frame(8'd255, 8'hCF, 8'h9F, 16'h5555);
        send_frame(8'd3, 8'h00, 8'h00, 16'h0001);
        send_frame(8'd2, 8'h20, 8'h47, 16'h7FFF);
        send_frame(8'd4, 8'h10, 8'h00, 16'h8000);
        for (i = 0; i < 1600; i++)
        begin
            k = $urandom_range(0, 9);
            u = 2'($urandom);
            typ = 8'($urandom);
            if (k < 3)
            begin
                page = 8'($urandom_range(2, 3));
                if ($urandom_range(0, 3) != 0)
                    typ[7:4] = 4'($urandom_range(0, 4));
                if ($urandom_range(0, 3) != 0)
                    typ[3] = 1'b0;
            end
            else if (k == 3)
            begin
                page = 8'd4;
            end
            else if (k == 4)
            begin
                page = 8'($urandom);
            end
            else
            begin
                page = $urandom_range(0, 1) ? 8'd0 : 8'd1;
            end
            send_frame(page, rnd_status(u), typ, 16'($urandom));
        end
        s_axis_tvalid <= 0;
        stim_done = 1;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: files.f
rtl/gfpc_pkg.sv
rtl/gfpc_front.sv
rtl/gfpc_queue.sv
rtl/gfpc_back.sv
rtl/gauge_frame_pressure_convert.sv
tb/sv/gfpc_checker.sv
tb/sv/testbench.sv
